// ----- hdl/tspb_pkg.sv -----
package tspb_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int WGT_W      = 17;
  localparam int SUM_W      = WGT_W + 1;
  localparam int NUM_W      = WGT_W + PIX_W + 1;
  localparam int QUO_W      = PIX_W;
  localparam int NUM_FIELDS = 3;

  // Default channel count for the top level
  localparam int CHANNELS_DEF = 3;

  // Weight fixed point and the negligible-sum threshold (a sum below 1e-6)
  localparam int unsigned WEIGHT_FRAC_BITS = 16;
  localparam longint unsigned NEG_SCALE    = 64'd1000000;
  localparam logic [SUM_W-1:0] NEG_LIMIT   =
    SUM_W'((((64'd1 << WEIGHT_FRAC_BITS) + NEG_SCALE) - 64'd1) / NEG_SCALE);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  typedef struct packed {
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_blue;
    logic [WGT_W-1:0] first_weight;
    logic [PIX_W-1:0] second_red;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_blue;
    logic [WGT_W-1:0] second_weight;
  } tspb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blend_red;
    logic [PIX_W-1:0] blend_green;
    logic [PIX_W-1:0] blend_blue;
  } tspb_out_t;

  // One division job: a numerator per channel and the shared divisor
  typedef struct packed {
    logic [NUM_FIELDS-1:0][NUM_W-1:0] num;
    logic [SUM_W-1:0]                 sum;
  } tspb_job_t;

endpackage

// ----- hdl/tspb_front.sv -----
module tspb_front #(
  parameter int CHANNELS = tspb_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tspb_pkg::tspb_in_t  in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output tspb_pkg::tspb_job_t job_data
);
  import tspb_pkg::*;

  localparam int LANES = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;

  logic                         vld_r;
  tspb_job_t                    job_r;
  tspb_job_t                    job_nxt;
  logic [NUM_FIELDS-1:0][PIX_W-1:0] pa;
  logic [NUM_FIELDS-1:0][PIX_W-1:0] pb;
  logic [SUM_W-1:0]             sum;
  logic                         black;
  logic                         advance;

  // Gather channels into lanes
  assign pa[0] = in_data.first_red;
  assign pa[1] = in_data.first_green;
  assign pa[2] = in_data.first_blue;
  assign pb[0] = in_data.second_red;
  assign pb[1] = in_data.second_green;
  assign pb[2] = in_data.second_blue;

  // Classify: weight sum and negligible-weight check
  assign sum   = SUM_W'(in_data.first_weight) + SUM_W'(in_data.second_weight);
  assign black = (sum < NEG_LIMIT);

  // Form weighted numerators; a black word becomes 0 / 1
  always_comb begin
    for (int l = 0; l < NUM_FIELDS; l++) begin
      job_nxt.num[l] = '0;
      if (l < LANES && !black) begin
        job_nxt.num[l] = NUM_W'(in_data.first_weight) * NUM_W'(pa[l])
                       + NUM_W'(in_data.second_weight) * NUM_W'(pb[l]);
      end
    end
    job_nxt.sum = black ? SUM_W'(1) : sum;
  end

  // Hold the word while the queue is full
  assign advance   = !vld_r || job_ready;
  assign in_stall  = !advance;
  assign job_valid = vld_r;
  assign job_data  = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ----- hdl/tspb_queue.sv -----
module tspb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  tspb_pkg::tspb_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_take,
  output tspb_pkg::tspb_job_t pop_data
);
  import tspb_pkg::*;

  tspb_job_t          slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = (cnt_r != Q_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_take && pop_valid;
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[Q_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- hdl/tspb_back.sv -----
module tspb_back #(
  parameter int CHANNELS = tspb_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_take,
  input  tspb_pkg::tspb_job_t job_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tspb_pkg::tspb_out_t out_data
);
  import tspb_pkg::*;

  localparam int LANES = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;

  logic                        vld_r [QUO_W+1];
  logic [LANES-1:0][NUM_W-1:0] rem_r [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0] quo_r [QUO_W+1];
  logic [SUM_W-1:0]            sum_r [QUO_W+1];
  logic                        en;
  logic [NUM_FIELDS-1:0][PIX_W-1:0] res;

  // Advance the whole divider unless the last word is stalled
  assign en       = !(vld_r[QUO_W] && out_stall);
  assign job_take = en;

  // Load a job from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= job_data.num[l];
        quo_r[0][l] <= '0;
      end
      sum_r[0] <= job_data.sum;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int BIT = QUO_W - s;
    logic [LANES-1:0][NUM_W-1:0] rem_nxt;
    logic [LANES-1:0][QUO_W-1:0] quo_nxt;
    logic [NUM_W:0]              shd;

    assign shd = (NUM_W + 1)'(sum_r[s-1]) << BIT;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[l] = rem_r[s-1][l];
        quo_nxt[l] = quo_r[s-1][l];
        if ({1'b0, rem_r[s-1][l]} >= shd) begin
          rem_nxt[l]      = rem_r[s-1][l] - shd[NUM_W-1:0];
          quo_nxt[l][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        sum_r[s] <= sum_r[s-1];
      end
    end
  end

  // Drive result fields; channels beyond the lane count read zero
  for (genvar l = 0; l < NUM_FIELDS; l++) begin : g_res
    if (l < LANES) begin : g_on
      assign res[l] = quo_r[QUO_W][l];
    end else begin : g_off
      assign res[l] = '0;
    end
  end

  assign out_valid          = vld_r[QUO_W];
  assign out_data.blend_red   = res[0];
  assign out_data.blend_green = res[1];
  assign out_data.blend_blue  = res[2];

  a_div_sum: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> sum_r[0] != '0)
    else $error("divider loaded with zero divisor");

  a_rem_low: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W] |-> (NUM_W + 1)'(rem_r[QUO_W][0]) < (NUM_W + 1)'(sum_r[QUO_W]))
    else $error("final remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[QUO_W] && out_stall) |=> vld_r[QUO_W] && $stable(quo_r[QUO_W]))
    else $error("stalled result changed");

endmodule

// ----- hdl/two_source_weighted_pixel_blend_top.sv -----
// Two-source weighted pixel blend. Each accepted word is a co-located pixel
// pair with a 17-bit weight per source (1.0 = 2^16); the result is
// (wa*a + wb*b) / (wa + wb) per channel, truncated, and black when the weight
// sum is below 1e-6. One pixel pair is taken every clock unless in_stall
// holds it off, and one result word leaves per input, in order. The front
// registers the products and weight sum at the accepting edge; the word
// then passes through the two-entry queue, the divider load register and
// the stages of the restoring divider, which resolves one quotient bit per
// stage. The output stall freezes the divider; the queue lets the front
// keep taking words while it has room.
module two_source_weighted_pixel_blend_top #(
  parameter int CHANNELS = tspb_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tspb_pkg::tspb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tspb_pkg::tspb_out_t out_data
);
  import tspb_pkg::*;

  logic      fq_valid;
  logic      fq_ready;
  tspb_job_t fq_data;
  logic      qb_valid;
  logic      qb_take;
  tspb_job_t qb_data;

  // Accept and classify
  tspb_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  // Decouple front and back
  tspb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_take   (qb_take),
    .pop_data   (qb_data)
  );

  // Divide and deliver
  tspb_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_take  (qb_take),
    .job_data  (qb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
